// File: rtl/core/joystick_axis_calibrate_normalize_macros.svh
// assertion macros used by the joystick axis calibration back end
// expects clk_i and rst_ni in the scope of each use
`ifndef JOYSTICK_AXIS_CALIBRATE_NORMALIZE_MACROS_SVH
`define JOYSTICK_AXIS_CALIBRATE_NORMALIZE_MACROS_SVH

// same-cycle implication
`define JACN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JACN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/jacn_pkg.sv
// shared constants, types and state encoding for the joystick axis calibration block
// no dependencies
package jacn_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int ELAPSED_W  = 20;
  localparam int DUR_W      = 26;
  localparam int NORM_W     = 16;
  localparam int CAL_T_W    = 27;
  localparam int CFG_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  // averaging ring
  localparam int RING_DEPTH = 20;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = $clog2(RING_DEPTH) + SAMPLE_W;
  // ring sum shifted to be non-negative, then divided by the ring depth through a reciprocal multiply
  localparam int U_W        = SUM_W;
  localparam int AVG_OFFSET = RING_DEPTH * 32768;
  localparam int RECIP_SH   = U_W;
  localparam int RECIP_W    = U_W + 1;
  localparam int RECIP_M    = (2 ** RECIP_SH) / RING_DEPTH;
  localparam int MUL_W      = U_W + RECIP_W;
  localparam int Q_W        = SAMPLE_W + 1;
  localparam int AVG_BIAS   = 32768;

  // input queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // normalisation divider
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int DIV_NUM_W   = 31;
  localparam int DIV_DEN_W   = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
  localparam int NORM_SHIFT  = 15;

  localparam int ELAPSED_MAX = (2 ** CAL_T_W) - 1;
  localparam int NORM_ONE    = 16384;
  localparam logic signed [NORM_W-1:0]   NORM_POS  = 16'sd16384;
  localparam logic signed [NORM_W-1:0]   NORM_NEG  = -16'sd16384;
  localparam logic signed [SAMPLE_W-1:0] RANGE_POS = 16'sd256;
  localparam logic signed [SAMPLE_W-1:0] RANGE_NEG = -16'sd256;

  // register reset values
  localparam logic [DUR_W-1:0]           DUR_RST      = 26'd15000000;
  localparam logic signed [SAMPLE_W-1:0] MIN_RST      = -16'sd3840;
  localparam logic signed [SAMPLE_W-1:0] MAX_RST      = 16'sd3328;
  localparam logic                       CONN_RST     = 1'b1;
  localparam logic signed [NORM_W-1:0]   FALLBACK_RST = 16'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_DURATION   = 3'd0,
    REG_INITIAL_MIN    = 3'd1,
    REG_INITIAL_MAX    = 3'd2,
    REG_AXIS_CONNECTED = 3'd3,
    REG_FALLBACK_NORM  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RING,
    ST_AVG_MUL,
    ST_AVG_FIX,
    ST_NORM,
    ST_DIV,
    ST_OUT
  } back_state_e;

  // one classified item from the front end
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [ELAPSED_W-1:0]       elapsed;
    logic                       start;
    logic                       samp_neg;
    logic                       samp_zero;
  } item_t;

  typedef struct packed {
    logic [DUR_W-1:0]         cal_duration;
    logic                     axis_connected;
    logic signed [NORM_W-1:0] fallback_norm;
  } cfg_t;

  // direct load of the stored range on a register write
  typedef struct packed {
    logic                       ld_min;
    logic                       ld_max;
    logic signed [SAMPLE_W-1:0] value;
  } range_ld_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]   norm_value;
    logic                       calibrating;
    logic                       cal_done;
    logic signed [SAMPLE_W-1:0] range_min;
    logic signed [SAMPLE_W-1:0] range_max;
  } result_t;

  typedef struct packed {
    logic pop;
    logic ring_upd;
    logic avg_mul;
    logic avg_fix;
    logic norm_direct;
    logic div_start;
    logic div_take;
    logic out_load;
  } back_ctl_t;

endpackage

// File: rtl/core/jacn_front.sv
// front end: accepts input items, classifies them and queues them for the back end
// depends on jacn_pkg
module jacn_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] axis_sample, [35:16] elapsed_us, [39:36] zero
  input  logic [jacn_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] start_cal
  input  logic [0:0]                        s_axis_tuser,
  input  logic                              pop_i,
  output logic                              item_valid_o,
  output jacn_pkg::item_t                   item_o
);

  jacn_pkg::item_t                   item_in;
  jacn_pkg::item_t                   queue_q [jacn_pkg::QUEUE_DEPTH];
  logic [jacn_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [jacn_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [jacn_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                              push;
  logic                              pop;

  always_comb begin
    item_in.sample    = $signed(s_axis_tdata[jacn_pkg::SAMPLE_W-1:0]);
    item_in.elapsed   = s_axis_tdata[jacn_pkg::SAMPLE_W +: jacn_pkg::ELAPSED_W];
    item_in.start     = s_axis_tuser[0];
    item_in.samp_neg  = s_axis_tdata[jacn_pkg::SAMPLE_W-1];
    item_in.samp_zero = (s_axis_tdata[jacn_pkg::SAMPLE_W-1:0] == '0);
  end

  assign s_axis_tready = (count_q != jacn_pkg::QCNT_W'(jacn_pkg::QUEUE_DEPTH));
  assign item_valid_o  = (count_q != '0);
  assign item_o        = queue_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == jacn_pkg::QPTR_W'(jacn_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + jacn_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == jacn_pkg::QPTR_W'(jacn_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + jacn_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + jacn_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - jacn_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// File: rtl/core/jacn_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on jacn_pkg
module jacn_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [jacn_pkg::DIV_NUM_W-1:0]  dividend_i,
  input  logic [jacn_pkg::DIV_DEN_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [jacn_pkg::DIV_NUM_W-1:0]  quot_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [jacn_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [jacn_pkg::DIV_DEN_W-1:0]  rem_q, rem_d;
  logic [jacn_pkg::DIV_NUM_W-1:0]  quot_q, quot_d;
  logic [jacn_pkg::DIV_DEN_W-1:0]  den_q;
  logic [jacn_pkg::DIV_DEN_W:0]    trial;
  logic                            ge;

  // dividend shifts out of the top while quotient bits enter at the bottom
  always_comb begin
    trial  = {rem_q, quot_q[jacn_pkg::DIV_NUM_W-1]};
    ge     = (trial >= {1'b0, den_q});
    rem_d  = ge ? jacn_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
                : trial[jacn_pkg::DIV_DEN_W-1:0];
    quot_d = {quot_q[jacn_pkg::DIV_NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= jacn_pkg::DIV_CNT_W'(jacn_pkg::DIV_NUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - jacn_pkg::DIV_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      den_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/core/jacn_back.sv
// back end: calibration sequencer, averaging ring, range tracking and normalisation
// depends on jacn_pkg, jacn_div and the assertion macro header
`include "joystick_axis_calibrate_normalize_macros.svh"

module jacn_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  jacn_pkg::item_t       item_i,
  output logic                  pop_o,
  input  jacn_pkg::cfg_t        cfg_i,
  input  jacn_pkg::range_ld_t   range_ld_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output jacn_pkg::result_t     result_o
);

  jacn_pkg::back_state_e state_q, state_d;
  jacn_pkg::back_ctl_t   ctl;

  jacn_pkg::item_t                        item_q;
  logic [jacn_pkg::SAMPLE_W-1:0]          ring_mem [jacn_pkg::RING_DEPTH];
  logic [jacn_pkg::RING_DEPTH-1:0]        ring_vld_q;
  logic [jacn_pkg::SAMPLE_W-1:0]          ring_rd_q;
  logic                                   ring_rd_vld_q;
  logic [jacn_pkg::RING_AW-1:0]           ring_pos_q, ring_pos_d;
  logic signed [jacn_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic signed [jacn_pkg::SAMPLE_W-1:0]   ring_old;
  logic [jacn_pkg::U_W-1:0]               avg_u;
  logic [jacn_pkg::MUL_W-1:0]             prod_q, prod_d;
  logic [jacn_pkg::Q_W-1:0]               q0, q_fix;
  logic [jacn_pkg::U_W:0]                 q_rem;
  logic signed [jacn_pkg::SAMPLE_W-1:0]   avg;
  logic signed [jacn_pkg::SAMPLE_W-1:0]   range_min_q, range_max_q;
  logic                                   cal_active_q;
  logic                                   cal_done_q;
  logic [jacn_pkg::CAL_T_W-1:0]           cal_elapsed_q, cal_elapsed_d;
  logic [jacn_pkg::CAL_T_W:0]             el_sum;
  logic                                   window_over;

  logic signed [jacn_pkg::DIFF_W-1:0]     diff;
  logic                                   diff_zero;
  logic                                   diff_neg;
  logic [jacn_pkg::DIFF_W-1:0]            diff_abs;
  logic [jacn_pkg::SAMPLE_W-1:0]          samp_mag;
  logic [jacn_pkg::DIV_NUM_W-1:0]         dividend;
  logic                                   res_neg_q;
  logic                                   div_done;
  logic [jacn_pkg::DIV_NUM_W-1:0]         quot;
  logic [jacn_pkg::NORM_W-1:0]            quot_sat;
  logic signed [jacn_pkg::NORM_W-1:0]     div_norm;
  logic signed [jacn_pkg::NORM_W-1:0]     direct_norm;
  logic signed [jacn_pkg::NORM_W-1:0]     norm_q;

  jacn_pkg::result_t                      res_q;
  logic                                   out_valid_q;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jacn_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          state_d = (item_i.start || cal_active_q) ? jacn_pkg::ST_RING : jacn_pkg::ST_NORM;
        end
      end
      jacn_pkg::ST_RING:    state_d = jacn_pkg::ST_AVG_MUL;
      jacn_pkg::ST_AVG_MUL: state_d = jacn_pkg::ST_AVG_FIX;
      jacn_pkg::ST_AVG_FIX: state_d = jacn_pkg::ST_NORM;
      jacn_pkg::ST_NORM: begin
        state_d = (cfg_i.axis_connected && !diff_zero) ? jacn_pkg::ST_DIV : jacn_pkg::ST_OUT;
      end
      jacn_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = jacn_pkg::ST_OUT;
        end
      end
      jacn_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = jacn_pkg::ST_IDLE;
        end
      end
      default: state_d = jacn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl             = '0;
    ctl.pop         = (state_q == jacn_pkg::ST_IDLE) && item_valid_i;
    ctl.ring_upd    = (state_q == jacn_pkg::ST_RING);
    ctl.avg_mul     = (state_q == jacn_pkg::ST_AVG_MUL);
    ctl.avg_fix     = (state_q == jacn_pkg::ST_AVG_FIX);
    ctl.norm_direct = (state_q == jacn_pkg::ST_NORM) && !(cfg_i.axis_connected && !diff_zero);
    ctl.div_start   = (state_q == jacn_pkg::ST_NORM) && cfg_i.axis_connected && !diff_zero;
    ctl.div_take    = (state_q == jacn_pkg::ST_DIV) && div_done;
    ctl.out_load    = (state_q == jacn_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jacn_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign pop_o = ctl.pop;

  // ---------------------------------------------------------------- ring
  always_ff @(posedge clk_i) begin
    if (ctl.pop) begin
      ring_rd_q <= ring_mem[ring_pos_q];
    end
    if (ctl.ring_upd) begin
      ring_mem[ring_pos_q] <= item_q.sample;
    end
  end

  always_comb begin
    // entries never written are read as zero through their valid bits
    ring_old   = ring_rd_vld_q ? $signed(ring_rd_q) : '0;
    sum_d      = sum_q - jacn_pkg::SUM_W'(ring_old) + jacn_pkg::SUM_W'(item_q.sample);
    ring_pos_d = (ring_pos_q == jacn_pkg::RING_AW'(jacn_pkg::RING_DEPTH - 1)) ? '0
               : ring_pos_q + jacn_pkg::RING_AW'(1);
    el_sum     = (jacn_pkg::CAL_T_W + 1)'(cal_elapsed_q)
               + (jacn_pkg::CAL_T_W + 1)'(item_q.elapsed);
    cal_elapsed_d = (el_sum > (jacn_pkg::CAL_T_W + 1)'(jacn_pkg::ELAPSED_MAX))
                  ? jacn_pkg::CAL_T_W'(jacn_pkg::ELAPSED_MAX)
                  : el_sum[jacn_pkg::CAL_T_W-1:0];
  end

  // floor average: bias to non-negative, reciprocal multiply, one correction step
  always_comb begin
    avg_u  = jacn_pkg::U_W'(sum_q) + jacn_pkg::U_W'(jacn_pkg::AVG_OFFSET);
    prod_d = jacn_pkg::MUL_W'(avg_u) * jacn_pkg::MUL_W'(jacn_pkg::RECIP_M);
    q0     = jacn_pkg::Q_W'(prod_q >> jacn_pkg::RECIP_SH);
    q_rem  = (jacn_pkg::U_W + 1)'(avg_u)
           - (jacn_pkg::U_W + 1)'(q0) * (jacn_pkg::U_W + 1)'(jacn_pkg::RING_DEPTH);
    q_fix  = (q_rem >= (jacn_pkg::U_W + 1)'(jacn_pkg::RING_DEPTH))
           ? q0 + jacn_pkg::Q_W'(1) : q0;
    avg    = $signed(jacn_pkg::SAMPLE_W'(q_fix - jacn_pkg::Q_W'(jacn_pkg::AVG_BIAS)));
    window_over = (cal_elapsed_q > jacn_pkg::CAL_T_W'(cfg_i.cal_duration));
  end

  always_ff @(posedge clk_i) begin
    if (ctl.pop) begin
      item_q <= item_i;
    end
    if (ctl.avg_mul) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q    <= '0;
      ring_rd_vld_q <= 1'b0;
      ring_pos_q    <= '0;
      sum_q         <= '0;
      range_min_q   <= jacn_pkg::MIN_RST;
      range_max_q   <= jacn_pkg::MAX_RST;
      cal_active_q  <= 1'b0;
      cal_done_q    <= 1'b0;
      cal_elapsed_q <= '0;
    end else begin
      if (ctl.pop) begin
        ring_rd_vld_q <= ring_vld_q[ring_pos_q];
        cal_done_q    <= 1'b0;
      end
      if (ctl.ring_upd) begin
        ring_vld_q[ring_pos_q] <= 1'b1;
        ring_pos_q             <= ring_pos_d;
        sum_q                  <= sum_d;
      end
      priority if (ctl.pop && item_i.start) begin
        cal_elapsed_q <= '0;
        cal_active_q  <= 1'b1;
      end else if (ctl.ring_upd) begin
        cal_elapsed_q <= cal_elapsed_d;
      end else if (ctl.avg_fix && window_over) begin
        cal_active_q <= 1'b0;
        cal_done_q   <= 1'b1;
      end
      // range: register load, then start of a window, then widening by the average
      priority if (range_ld_i.ld_min) begin
        range_min_q <= range_ld_i.value;
      end else if (ctl.pop && item_i.start) begin
        range_min_q <= jacn_pkg::RANGE_NEG;
      end else if (ctl.avg_fix && (avg < range_min_q)) begin
        range_min_q <= avg;
      end
      priority if (range_ld_i.ld_max) begin
        range_max_q <= range_ld_i.value;
      end else if (ctl.pop && item_i.start) begin
        range_max_q <= jacn_pkg::RANGE_POS;
      end else if (ctl.avg_fix && (avg > range_max_q)) begin
        range_max_q <= avg;
      end
    end
  end

  // ---------------------------------------------------------------- normalisation
  always_comb begin
    diff      = jacn_pkg::DIFF_W'(range_max_q) - jacn_pkg::DIFF_W'(range_min_q);
    diff_zero = (diff == '0);
    diff_neg  = diff[jacn_pkg::DIFF_W-1];
    diff_abs  = diff_neg ? jacn_pkg::DIFF_W'(-diff) : jacn_pkg::DIFF_W'(diff);
    samp_mag  = item_q.samp_neg ? jacn_pkg::SAMPLE_W'(-item_q.sample)
                                : jacn_pkg::SAMPLE_W'(item_q.sample);
    dividend  = jacn_pkg::DIV_NUM_W'(samp_mag) << jacn_pkg::NORM_SHIFT;
    quot_sat  = (quot > jacn_pkg::DIV_NUM_W'(jacn_pkg::NORM_ONE))
              ? jacn_pkg::NORM_W'(jacn_pkg::NORM_ONE) : jacn_pkg::NORM_W'(quot);
    div_norm  = res_neg_q ? $signed(jacn_pkg::NORM_W'(-quot_sat)) : $signed(quot_sat);
    if (!cfg_i.axis_connected) begin
      if (cfg_i.fallback_norm > jacn_pkg::NORM_POS) begin
        direct_norm = jacn_pkg::NORM_POS;
      end else if (cfg_i.fallback_norm < jacn_pkg::NORM_NEG) begin
        direct_norm = jacn_pkg::NORM_NEG;
      end else begin
        direct_norm = cfg_i.fallback_norm;
      end
    end else if (item_q.samp_zero) begin
      direct_norm = '0;
    end else begin
      // zero range saturates by sample sign
      direct_norm = item_q.samp_neg ? jacn_pkg::NORM_NEG : jacn_pkg::NORM_POS;
    end
  end

  jacn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (dividend),
    .divisor_i  (diff_abs[jacn_pkg::DIV_DEN_W-1:0]),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (ctl.div_start) begin
      res_neg_q <= item_q.samp_neg ^ diff_neg;
    end
    if (ctl.norm_direct) begin
      norm_q <= direct_norm;
    end else if (ctl.div_take) begin
      norm_q <= div_norm;
    end
    if (ctl.out_load) begin
      res_q.norm_value  <= norm_q;
      res_q.calibrating <= cal_active_q;
      res_q.cal_done    <= cal_done_q;
      res_q.range_min   <= range_min_q;
      res_q.range_max   <= range_max_q;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // ---------------------------------------------------------------- assertions
  `JACN_ASSERT_IMP(a_ring_pos_range, 1'b1, int'(ring_pos_q) < jacn_pkg::RING_DEPTH,
    "ring position past ring depth")
  `JACN_ASSERT_IMP(a_div_done_in_div, div_done, state_q == jacn_pkg::ST_DIV,
    "divider finished outside the divide state")
  `JACN_ASSERT_IMP(a_ring_only_cal, state_q == jacn_pkg::ST_RING, cal_active_q,
    "ring updated without an open calibration window")
  `JACN_ASSERT_IMP(a_done_ends_cal, out_valid_q && res_q.cal_done, !res_q.calibrating,
    "calibration done reported while still calibrating")
  `JACN_ASSERT_NXT(a_out_load, ctl.out_load, out_valid_q && (state_q == jacn_pkg::ST_IDLE),
    "result load did not present an item")

endmodule

// File: rtl/core/joystick_axis_calibrate_normalize.sv
// Joystick axis calibration and normalisation. Each input item carries one Q8.8 axis
// sample, the microseconds since the previous item and a start-calibration flag; each
// item gives exactly one result: the sample scaled to 2*sample/(max-min) in Q1.14,
// saturated to +/-1.0, with the calibration flags and the stored range. A start sets
// the range to +/-1.0 and opens a window during which a 20-entry moving average widens
// the range until the configured duration has passed. Items are worked one at a time:
// an item passes through the ring update and the averaging multiply and correction only
// while calibrating, and through the 31-step serial divider only with an axis connected
// and a nonzero range. A two-entry input queue and an output register let the input
// and output sides stall independently. Configuration writes must be made while idle;
// writing initial_min or initial_max also loads the stored range at once.
// depends on jacn_pkg, jacn_front, jacn_back
module joystick_axis_calibrate_normalize (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] axis_sample, [35:16] elapsed_us, [39:36] zero
  input  logic [jacn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] start_cal
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] norm_value, [31:16] range_min_out, [47:32] range_max_out
  output logic [jacn_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] calibrating, [1] cal_done
  output logic [jacn_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [jacn_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [jacn_pkg::CFG_W-1:0]          cfg_wdata_i
);

  jacn_pkg::cfg_t        cfg_q;
  jacn_pkg::range_ld_t   range_ld;
  jacn_pkg::item_t       item;
  jacn_pkg::result_t     result;
  logic                  item_valid;
  logic                  pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_duration   <= jacn_pkg::DUR_RST;
      cfg_q.axis_connected <= jacn_pkg::CONN_RST;
      cfg_q.fallback_norm  <= jacn_pkg::FALLBACK_RST;
    end else if (cfg_we_i) begin
      unique case (jacn_pkg::cfg_reg_e'(cfg_idx_i))
        jacn_pkg::REG_CAL_DURATION:   cfg_q.cal_duration   <= cfg_wdata_i[jacn_pkg::DUR_W-1:0];
        jacn_pkg::REG_AXIS_CONNECTED: cfg_q.axis_connected <= cfg_wdata_i[0];
        jacn_pkg::REG_FALLBACK_NORM:  cfg_q.fallback_norm  <=
                                        $signed(cfg_wdata_i[jacn_pkg::NORM_W-1:0]);
        default: ;
      endcase
    end
  end

  // initial range writes go straight into the stored range
  always_comb begin
    range_ld.ld_min = cfg_we_i && (cfg_idx_i == jacn_pkg::REG_INITIAL_MIN);
    range_ld.ld_max = cfg_we_i && (cfg_idx_i == jacn_pkg::REG_INITIAL_MAX);
    range_ld.value  = range_ld.ld_min ? $signed(cfg_wdata_i[jacn_pkg::SAMPLE_W-1:0])
                    : $signed({1'b0, cfg_wdata_i[jacn_pkg::SAMPLE_W-2:0]});
  end

  jacn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_i         (pop),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  jacn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .cfg_i        (cfg_q),
    .range_ld_i   (range_ld),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (result)
  );

  assign m_axis_tdata = {result.range_max, result.range_min, result.norm_value};
  assign m_axis_tuser = {result.cal_done, result.calibrating};

endmodule
